FILE: rtl/assert_macros.svh
// Assertion macros for the checker of the Q-learning table engine.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on the rising clock edge, off while reset is low.
`define QLTE_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion sampled on the rising clock edge, also checked during reset.
`define QLTE_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/qlte_pkg.sv
// Package of the Q-learning table engine: defaults, register and mode codes, word types.
// Depends on nothing; every module of the engine imports it.
package qlte_pkg;

    localparam int QLTE_STATE_COUNT  = 128;
    localparam int QLTE_ACTION_COUNT = 4;
    localparam int QLTE_Q_WIDTH      = 16;

    localparam int APB_AW    = 4;
    localparam int REG_IDX_W = 2;

    localparam logic [REG_IDX_W-1:0] REG_LEARN_RATE   = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_DISCOUNT     = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_EXPLORE_RATE = 2'd2;

    localparam logic [15:0] LEARN_RATE_RST   = 16'd6554;
    localparam logic [15:0] DISCOUNT_RST     = 16'd58982;
    localparam logic [15:0] EXPLORE_RATE_RST = 16'd6554;

    localparam logic MODE_CHOOSE = 1'b0;
    localparam logic MODE_UPDATE = 1'b1;

    typedef struct packed {
        logic [15:0] learn_rate;
        logic [15:0] discount;
        logic [15:0] explore_rate;
    } t_cfg;

    typedef struct packed {
        logic               mode;
        logic [6:0]         state_index;
        logic [1:0]         action_index;
        logic [6:0]         next_state_index;
        logic signed [15:0] reward_value;
        logic [15:0]        random_draw;
        logic [1:0]         random_action;
    } t_item;

    typedef struct packed {
        logic [1:0]         chosen_action;
        logic               explored;
        logic signed [15:0] new_q_value;
        logic               saturated;
    } t_result;

endpackage

FILE: rtl/qlte_cfg.sv
// APB register file of the Q-learning table engine: learn rate, discount, explore rate.
// Depends on qlte_pkg.
module qlte_cfg
    import qlte_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;
    t_cfg                 r_cfg;

    assign reg_idx = paddr[APB_AW-1:2];
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.learn_rate   <= LEARN_RATE_RST;
            r_cfg.discount     <= DISCOUNT_RST;
            r_cfg.explore_rate <= EXPLORE_RATE_RST;
        end else if (wr_en) begin
            case (reg_idx)
                REG_LEARN_RATE:   r_cfg.learn_rate   <= pwdata[15:0];
                REG_DISCOUNT:     r_cfg.discount     <= pwdata[15:0];
                REG_EXPLORE_RATE: r_cfg.explore_rate <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_LEARN_RATE:   prdata = {16'b0, r_cfg.learn_rate};
            REG_DISCOUNT:     prdata = {16'b0, r_cfg.discount};
            REG_EXPLORE_RATE: prdata = {16'b0, r_cfg.explore_rate};
            default:          prdata = 32'b0;
        endcase
    end

endmodule

FILE: rtl/qlte_mem.sv
// Row-wide Q-table memory, one row per state, with a zero-fill pass after reset.
// Depends on qlte_pkg for its parameter defaults; read data is registered.
module qlte_mem
    import qlte_pkg::*;
#(
    parameter int STATE_COUNT = QLTE_STATE_COUNT,
    parameter int ROW_W       = QLTE_ACTION_COUNT * QLTE_Q_WIDTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_rd_en,
    input  logic [$clog2(STATE_COUNT)-1:0] i_rd_addr,
    output logic [ROW_W-1:0]               o_rd_data,
    input  logic                           i_wr_en,
    input  logic [$clog2(STATE_COUNT)-1:0] i_wr_addr,
    input  logic [ROW_W-1:0]               i_wr_data,
    output logic                           o_busy
);

    localparam int AW = $clog2(STATE_COUNT);

    logic [ROW_W-1:0] r_mem [STATE_COUNT];
    logic [ROW_W-1:0] r_rd_data;
    logic             r_busy;
    logic [AW-1:0]    r_clr_addr;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [ROW_W-1:0] wr_data;

    assign o_busy    = r_busy;
    assign o_rd_data = r_rd_data;
    assign wr_en     = r_busy || i_wr_en;
    assign wr_addr   = r_busy ? r_clr_addr : i_wr_addr;
    assign wr_data   = r_busy ? '0 : i_wr_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_busy) begin
            if (r_clr_addr == AW'(STATE_COUNT - 1)) begin
                r_busy <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

FILE: rtl/qlte_core.sv
// Sequencer of the Q-learning table engine: row scan for argmax and maximum,
// Bellman update with two registered multiplies, write-back and output register.
// Depends on qlte_pkg and drives the row memory qlte_mem.
module qlte_core
    import qlte_pkg::*;
#(
    parameter int STATE_COUNT  = QLTE_STATE_COUNT,
    parameter int ACTION_COUNT = QLTE_ACTION_COUNT,
    parameter int Q_WIDTH      = QLTE_Q_WIDTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  t_cfg                            i_cfg,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  t_item                           i_item,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output t_result                         o_result,
    output logic                            o_mem_rd_en,
    output logic [$clog2(STATE_COUNT)-1:0]  o_mem_rd_addr,
    input  logic [ACTION_COUNT*Q_WIDTH-1:0] i_mem_rd_data,
    output logic                            o_mem_wr_en,
    output logic [$clog2(STATE_COUNT)-1:0]  o_mem_wr_addr,
    output logic [ACTION_COUNT*Q_WIDTH-1:0] o_mem_wr_data,
    input  logic                            i_mem_busy
);

    localparam int SW  = $clog2(STATE_COUNT);
    localparam int AW  = $clog2(ACTION_COUNT);
    localparam int PGW = Q_WIDTH + 17;
    localparam int TW  = ((Q_WIDTH > 16) ? Q_WIDTH : 16) + 3;
    localparam int PDW = TW + 17;
    localparam int NW  = TW + 2;
    localparam logic signed [NW-1:0] QMAX = NW'((64'sd1 <<< (Q_WIDTH - 1)) - 64'sd1);
    localparam logic signed [NW-1:0] QMIN = NW'(-(64'sd1 <<< (Q_WIDTH - 1)));
    localparam logic signed [PGW-1:0] G_HALF = PGW'(32768);
    localparam logic signed [PDW-1:0] D_HALF = PDW'(32768);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_LOAD = 3'd1;
    localparam logic [2:0] ST_SCAN = 3'd2;
    localparam logic [2:0] ST_MULG = 3'd3;
    localparam logic [2:0] ST_DIFF = 3'd4;
    localparam logic [2:0] ST_MULD = 3'd5;
    localparam logic [2:0] ST_DONE = 3'd6;

    function automatic logic [SW-1:0] state_mod(input logic [6:0] v);
        logic [SW-1:0] r;
        r = '0;
        for (int k = 0; k < 128; k++) begin
            if (v == 7'(k)) begin
                r = SW'(k % STATE_COUNT);
            end
        end
        return r;
    endfunction

    function automatic logic [AW-1:0] action_mod(input logic [1:0] v);
        logic [AW-1:0] r;
        r = '0;
        for (int k = 0; k < 4; k++) begin
            if (v == 2'(k)) begin
                r = AW'(k % ACTION_COUNT);
            end
        end
        return r;
    endfunction

    logic [2:0]                 r_state;
    logic [2:0]                 n_state;
    logic                       r_mode;
    logic [SW-1:0]              r_s;
    logic [AW-1:0]              r_a;
    logic [AW-1:0]              r_ract;
    logic signed [15:0]         r_reward;
    logic [15:0]                r_draw;
    logic [AW-1:0]              r_k;
    logic signed [Q_WIDTH-1:0]  r_best;
    logic [AW-1:0]              r_best_idx;
    logic signed [PGW-1:0]      r_prod_g;
    logic signed [TW-1:0]       r_t;
    logic signed [Q_WIDTH-1:0]  r_q;
    logic signed [PDW-1:0]      r_prod_d;
    logic                       r_out_valid;
    t_result                    r_out;

    logic signed [Q_WIDTH-1:0]  ent [ACTION_COUNT];
    logic                       accept;
    logic                       load_out;
    logic signed [PGW-1:0]      g_sum;
    logic signed [Q_WIDTH:0]    g_val;
    logic signed [TW-1:0]       t_val;
    logic signed [PDW-1:0]      d_sum;
    logic signed [TW:0]         d_val;
    logic signed [NW-1:0]       nv;
    logic signed [Q_WIDTH-1:0]  sat_val;
    logic                       sat;
    logic                       explore;
    t_result                    n_out;

    always_comb begin
        for (int k = 0; k < ACTION_COUNT; k++) begin
            ent[k] = i_mem_rd_data[k*Q_WIDTH +: Q_WIDTH];
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE) && !i_mem_busy;
    assign accept      = i_in_valid && o_in_ready;
    assign load_out    = (r_state == ST_DONE) && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

    assign o_mem_rd_en   = accept || (r_state == ST_MULG);
    assign o_mem_rd_addr = (r_state == ST_MULG) ? r_s :
                           ((i_item.mode == MODE_UPDATE) ? state_mod(i_item.next_state_index)
                                                         : state_mod(i_item.state_index));

    // Rounding to nearest with ties upward is a floor after adding one half.
    assign g_sum = r_prod_g + G_HALF;
    assign g_val = g_sum[PGW-1:16];
    assign t_val = TW'(r_reward) + TW'(g_val) - TW'(ent[r_a]);
    assign d_sum = r_prod_d + D_HALF;
    assign d_val = d_sum[PDW-1:16];
    assign nv    = NW'(r_q) + NW'(d_val);

    always_comb begin
        sat     = 1'b0;
        sat_val = Q_WIDTH'(nv);
        if (nv > QMAX) begin
            sat     = 1'b1;
            sat_val = Q_WIDTH'(QMAX);
        end else if (nv < QMIN) begin
            sat     = 1'b1;
            sat_val = Q_WIDTH'(QMIN);
        end
    end

    assign explore = r_draw < i_cfg.explore_rate;

    always_comb begin
        n_out = '0;
        if (r_mode == MODE_UPDATE) begin
            n_out.new_q_value = 16'(sat_val);
            n_out.saturated   = sat;
        end else begin
            n_out.explored      = explore;
            n_out.chosen_action = explore ? 2'(r_ract) : 2'(r_best_idx);
        end
    end

    always_comb begin
        o_mem_wr_data = i_mem_rd_data;
        o_mem_wr_data[r_a*Q_WIDTH +: Q_WIDTH] = sat_val;
    end
    assign o_mem_wr_addr = r_s;
    assign o_mem_wr_en   = load_out && (r_mode == MODE_UPDATE);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (accept) n_state = ST_LOAD;
            ST_LOAD: n_state = ST_SCAN;
            ST_SCAN: begin
                if (r_k == AW'(ACTION_COUNT - 1)) begin
                    n_state = (r_mode == MODE_UPDATE) ? ST_MULG : ST_DONE;
                end
            end
            ST_MULG: n_state = ST_DIFF;
            ST_DIFF: n_state = ST_MULD;
            ST_MULD: n_state = ST_DONE;
            ST_DONE: if (load_out) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode   <= i_item.mode;
            r_s      <= state_mod(i_item.state_index);
            r_a      <= action_mod(i_item.action_index);
            r_ract   <= action_mod(i_item.random_action);
            r_reward <= i_item.reward_value;
            r_draw   <= i_item.random_draw;
        end
        case (r_state)
            ST_LOAD: begin
                r_best     <= ent[0];
                r_best_idx <= '0;
                r_k        <= AW'(1);
            end
            ST_SCAN: begin
                if (ent[r_k] > r_best) begin
                    r_best     <= ent[r_k];
                    r_best_idx <= r_k;
                end
                r_k <= r_k + AW'(1);
            end
            ST_MULG: r_prod_g <= $signed({1'b0, i_cfg.discount}) * r_best;
            ST_DIFF: begin
                r_t <= t_val;
                r_q <= ent[r_a];
            end
            ST_MULD: r_prod_d <= $signed({1'b0, i_cfg.learn_rate}) * r_t;
            default: ;
        endcase
        if (load_out) begin
            r_out <= n_out;
        end
    end

endmodule

FILE: rtl/q_learning_table_engine_top.sv
// Q-learning table engine: a choose word scans the columns of one row from the single row
// memory for the best action; an update word scans the next state's row for its maximum,
// then reads the current state's row and runs the two chained multiplies; one word at a time,
// the next accepted in the cycle after the result register loads.
// Reset is synchronous and active low; after it the table memory is zero-filled one row
// per cycle, all STATE_COUNT rows (128 by default), while s_axis_tready stays low.
module q_learning_table_engine_top
    import qlte_pkg::*;
#(
    parameter int STATE_COUNT  = QLTE_STATE_COUNT,
    parameter int ACTION_COUNT = QLTE_ACTION_COUNT,
    parameter int Q_WIDTH      = QLTE_Q_WIDTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // state_index[6:0], action_index[8:7], next_state_index[15:9], reward_value[31:16],
    // random_draw[47:32], random_action[49:48], zero fill[55:50]
    input  logic [55:0]       s_axis_tdata,
    // mode[0]
    input  logic              s_axis_tuser,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // chosen_action[1:0], explored[2], new_q_value[18:3], saturated[19], zero fill[23:20]
    output logic [23:0]       m_axis_tdata,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int SW    = $clog2(STATE_COUNT);
    localparam int ROW_W = ACTION_COUNT * Q_WIDTH;

    t_cfg             cfg;
    t_item            item;
    t_result          result;
    logic             mem_rd_en;
    logic [SW-1:0]    mem_rd_addr;
    logic [ROW_W-1:0] mem_rd_data;
    logic             mem_wr_en;
    logic [SW-1:0]    mem_wr_addr;
    logic [ROW_W-1:0] mem_wr_data;
    logic             mem_busy;

    assign item.mode             = s_axis_tuser;
    assign item.state_index      = s_axis_tdata[6:0];
    assign item.action_index     = s_axis_tdata[8:7];
    assign item.next_state_index = s_axis_tdata[15:9];
    assign item.reward_value     = s_axis_tdata[31:16];
    assign item.random_draw      = s_axis_tdata[47:32];
    assign item.random_action    = s_axis_tdata[49:48];

    assign m_axis_tdata = {4'b0, result.saturated, result.new_q_value,
                           result.explored, result.chosen_action};

    qlte_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    qlte_mem #(
        .STATE_COUNT (STATE_COUNT),
        .ROW_W       (ROW_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .o_busy    (mem_busy)
    );

    qlte_core #(
        .STATE_COUNT  (STATE_COUNT),
        .ACTION_COUNT (ACTION_COUNT),
        .Q_WIDTH      (Q_WIDTH)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_in_valid    (s_axis_tvalid),
        .o_in_ready    (s_axis_tready),
        .i_item        (item),
        .o_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .o_result      (result),
        .o_mem_rd_en   (mem_rd_en),
        .o_mem_rd_addr (mem_rd_addr),
        .i_mem_rd_data (mem_rd_data),
        .o_mem_wr_en   (mem_wr_en),
        .o_mem_wr_addr (mem_wr_addr),
        .o_mem_wr_data (mem_wr_data),
        .i_mem_busy    (mem_busy)
    );

endmodule

FILE: rtl/qlte_checker.sv
// Port-level checker of the Q-learning table engine, bound to the top level.
// Depends on qlte_pkg and assert_macros.svh.
`include "assert_macros.svh"

module qlte_checker
    import qlte_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              s_axis_tvalid,
    input logic              s_axis_tready,
    input logic [55:0]       s_axis_tdata,
    input logic              s_axis_tuser,
    input logic              m_axis_tvalid,
    input logic              m_axis_tready,
    input logic [23:0]       m_axis_tdata,
    input logic              psel,
    input logic              penable,
    input logic              pwrite,
    input logic [APB_AW-1:0] paddr,
    input logic [31:0]       pwdata,
    input logic [31:0]       prdata,
    input logic              pready
);

    `QLTE_ASSERT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "result word dropped while stalled")
    `QLTE_ASSERT(a_out_stable, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata), "result word changed while stalled")
    `QLTE_ASSERT(a_one_at_a_time, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "input accepted while a word is in work")
    `QLTE_ASSERT_ALWAYS(a_reset_quiet, i_clk, !i_rst_n |=> !m_axis_tvalid && !s_axis_tready, "handshake active right after reset")

endmodule

bind q_learning_table_engine_top qlte_checker u_qlte_checker (.*);
